// ----- hw/rtl/arm64_prologue_relocator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the relocator checker
// ---------------------------------------------------------------------------
`ifndef ARM64_PROLOGUE_RELOCATOR_MACROS_SVH
`define ARM64_PROLOGUE_RELOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define A64PR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define A64PR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/a64pr_pkg.sv -----
// ---------------------------------------------------------------------------
// a64pr_pkg
// Shared types, status codes and sizing constants of the prologue relocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package a64pr_pkg;

    // Window and buffer limits
    localparam int MAX_WINDOW_INSNS = 64;
    localparam int MAX_RELOC_BYTES  = 24;
    localparam int MAX_OUT_BYTES    = 4096;
    localparam int IDX_W            = $clog2(MAX_WINDOW_INSNS);

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_IN_WIN  = 3'd1;
    localparam logic [2:0] ST_UNALLOC = 3'd2;
    localparam logic [2:0] ST_CAP     = 3'd3;
    localparam logic [2:0] ST_SKIP    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_CAP   = 2'd2;

    // Replacement sequence selected by the front end
    typedef enum logic [3:0] {
        K_COPY,
        K_NOP,
        K_ADR,
        K_B,
        K_BL,
        K_COND19,
        K_COND14,
        K_LIT,
        K_FAIL
    } t_kind;

    // One classified instruction on its way to the back end
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  status;
        logic [31:0] insn;
        logic [63:0] target;
        logic [12:0] bytes;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    // Number of words a sequence expands into
    function automatic logic [2:0] words_of(input t_kind kind);
        logic [2:0] n;
        unique case (kind)
            K_ADR, K_B:          n = 3'd4;
            K_BL, K_LIT:         n = 3'd5;
            K_COND19, K_COND14:  n = 3'd6;
            default:             n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// ----- hw/rtl/a64pr_queue.sv -----
// ---------------------------------------------------------------------------
// a64pr_queue
// Two-entry descriptor queue between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module a64pr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  a64pr_pkg::t_push  i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output a64pr_pkg::t_desc  o_desc
);

    a64pr_pkg::t_desc r_mem [2];
    logic [0:0]       r_wr_ptr;
    logic [0:0]       r_rd_ptr;
    logic [1:0]       r_count;
    logic             pop_ok;

    assign pop_ok  = i_pop && (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Store pushed descriptors
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push.valid, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/a64pr_front.sv -----
// ---------------------------------------------------------------------------
// a64pr_front
// Holds configuration and window state, classifies each instruction,
// resolves its target address and status, and pushes a descriptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module a64pr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic [31:0]       i_instruction,
    input  logic              i_full,
    output a64pr_pkg::t_push  o_push
);

    localparam int IDX_W = a64pr_pkg::IDX_W;
    localparam logic [6:0]  CNT_MAX = 7'(a64pr_pkg::MAX_WINDOW_INSNS);
    localparam logic [12:0] CAP_MAX = 13'(a64pr_pkg::MAX_OUT_BYTES);
    localparam logic [13:0] RELOC   = 14'(a64pr_pkg::MAX_RELOC_BYTES);

    // Configuration
    logic [63:0] r_base;
    logic [6:0]  r_count;
    logic [12:0] r_cap;

    // Window state
    logic [IDX_W-1:0] r_idx;
    logic [12:0]      r_bytes;
    logic             r_failed;

    logic             accept;
    logic [6:0]       cnt_eff;
    logic [12:0]      cap_eff;
    logic             is_adr, is_b, is_c19, is_c14, is_lit;
    logic [29:0]      off;
    logic [29:0]      rel;
    logic [12:0]      low_sum;
    logic [51:0]      page;
    logic [63:0]      t_rel;
    logic [63:0]      target;
    logic [63:0]      hi;
    logic             in_win;
    a64pr_pkg::t_kind kind;
    logic [2:0]       cls_status;
    logic [2:0]       status;
    logic             win_end;

    assign accept = i_in_valid && !i_full;

    // Clamp count and capacity
    always_comb begin
        if (r_count == 7'd0) begin
            cnt_eff = 7'd1;
        end else if (r_count > CNT_MAX) begin
            cnt_eff = CNT_MAX;
        end else begin
            cnt_eff = r_count;
        end
        cap_eff = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    end

    // Decode instruction class
    assign is_adr = (i_instruction & 32'h1F00_0000) == 32'h1000_0000;
    assign is_b   = (i_instruction & 32'h7C00_0000) == 32'h1400_0000;
    assign is_c19 = ((i_instruction & 32'hFF00_0010) == 32'h5400_0000)
                 || ((i_instruction & 32'h7E00_0000) == 32'h3400_0000);
    assign is_c14 = (i_instruction & 32'h7E00_0000) == 32'h3600_0000;
    assign is_lit = (i_instruction & 32'h3B00_0000) == 32'h1800_0000;

    // Select the signed byte offset of the encoded immediate
    always_comb begin
        priority if (is_adr) begin
            off = {{9{i_instruction[23]}}, i_instruction[23:5], i_instruction[30:29]};
        end else if (is_b) begin
            off = {{2{i_instruction[25]}}, i_instruction[25:0], 2'b00};
        end else if (is_c14) begin
            off = {{14{i_instruction[18]}}, i_instruction[18:5], 2'b00};
        end else begin
            off = {{9{i_instruction[23]}}, i_instruction[23:5], 2'b00};
        end
    end

    // Resolve the target: pc-relative, or page-relative for ADRP
    assign rel     = off + {{(28-IDX_W){1'b0}}, r_idx, 2'b00};
    assign t_rel   = r_base + {{34{rel[29]}}, rel};
    assign low_sum = {1'b0, r_base[11:0]} + {{(11-IDX_W){1'b0}}, r_idx, 2'b00};
    assign page    = r_base[63:12] + {{31{i_instruction[23]}}, i_instruction[23:5],
                                      i_instruction[30:29]} + {51'b0, low_sum[12]};
    assign target  = (is_adr && i_instruction[31]) ? {page, 12'h000} : t_rel;

    // Window bounds check
    assign hi     = r_base + {55'b0, cnt_eff, 2'b00};
    assign in_win = (target >= r_base) && (target < hi);

    // Pick the replacement sequence
    always_comb begin
        cls_status = a64pr_pkg::ST_OK;
        kind       = a64pr_pkg::K_COPY;
        priority if (is_adr) begin
            kind = a64pr_pkg::K_ADR;
        end else if (is_b) begin
            kind = i_instruction[31] ? a64pr_pkg::K_BL : a64pr_pkg::K_B;
            if (in_win) begin
                cls_status = a64pr_pkg::ST_IN_WIN;
            end
        end else if (is_c19 || is_c14) begin
            kind = is_c19 ? a64pr_pkg::K_COND19 : a64pr_pkg::K_COND14;
            if (in_win) begin
                cls_status = a64pr_pkg::ST_IN_WIN;
            end
        end else if (is_lit) begin
            if (i_instruction[31:30] == 2'b11) begin
                kind = a64pr_pkg::K_NOP;
                if (i_instruction[26]) begin
                    cls_status = a64pr_pkg::ST_UNALLOC;
                end
            end else begin
                kind = a64pr_pkg::K_LIT;
            end
        end else begin
            kind = a64pr_pkg::K_COPY;
        end
    end

    // Apply skip and capacity checks ahead of the class result
    always_comb begin
        priority if (r_failed) begin
            status = a64pr_pkg::ST_SKIP;
        end else if ({1'b0, r_bytes} + RELOC > {1'b0, cap_eff}) begin
            status = a64pr_pkg::ST_CAP;
        end else begin
            status = cls_status;
        end
    end

    assign win_end = ({1'b0, r_idx} + 7'd1) >= cnt_eff;

    // Build the descriptor
    always_comb begin
        o_push.valid       = accept;
        o_push.desc.kind   = (status != a64pr_pkg::ST_OK) ? a64pr_pkg::K_FAIL : kind;
        o_push.desc.status = status;
        o_push.desc.insn   = i_instruction;
        o_push.desc.target = target;
        o_push.desc.bytes  = r_bytes;
    end

    // Hold configuration, advance window state per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= 64'd0;
            r_count  <= 7'd1;
            r_cap    <= CAP_MAX;
            r_idx    <= '0;
            r_bytes  <= 13'd0;
            r_failed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    a64pr_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                    a64pr_pkg::CFG_COUNT: r_count <= i_cfg_data[6:0];
                    a64pr_pkg::CFG_CAP:   r_cap   <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (win_end) begin
                    r_idx    <= '0;
                    r_bytes  <= 13'd0;
                    r_failed <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    if (status != a64pr_pkg::ST_OK) begin
                        r_failed <= 1'b1;
                    end else begin
                        r_bytes <= r_bytes + {8'b0, a64pr_pkg::words_of(kind), 2'b00};
                    end
                end
            end
        end
    end

endmodule

// ----- hw/rtl/a64pr_back.sv -----
// ---------------------------------------------------------------------------
// a64pr_back
// Expands each queued descriptor into its replacement words, one word per
// cycle while the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module a64pr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  a64pr_pkg::t_desc  i_q_desc,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_word,
    output logic              o_word_last,
    output logic [2:0]        o_status,
    output logic [12:0]       o_bytes_total
);

    localparam logic [31:0] OP_LDR_LIT = 32'h5800_0000;
    localparam logic [31:0] OP_B       = 32'h1400_0000;
    localparam logic [31:0] OP_BR      = 32'hD61F_0000;
    localparam logic [31:0] OP_BLR     = 32'hD63F_0000;
    localparam logic [31:0] OP_NOP     = 32'hD503_201F;
    localparam logic [4:0]  X16        = 5'd16;
    localparam logic [4:0]  X17        = 5'd17;

    logic        r_valid;
    logic [31:0] r_word;
    logic        r_last;
    logic [2:0]  r_status;
    logic [12:0] r_bytes;
    logic [2:0]  r_k;

    logic        load;
    logic        last;
    logic [2:0]  k_next;
    logic [31:0] word;

    function automatic logic [31:0] ldr_lit(input logic [4:0] rt, input logic [18:0] w);
        return OP_LDR_LIT | {8'b0, w, rt};
    endfunction

    function automatic logic [31:0] enc_b(input logic [25:0] w);
        return OP_B | {6'b0, w};
    endfunction

    function automatic logic [31:0] lit_load(input logic [31:0] insn);
        logic [31:0] op;
        unique case ({insn[26], insn[31:30]})
            3'b000:  op = 32'hB940_0000;
            3'b001:  op = 32'hF940_0000;
            3'b010:  op = 32'hB980_0000;
            3'b100:  op = 32'hBD40_0000;
            3'b101:  op = 32'hFD40_0000;
            3'b110:  op = 32'h3DC0_0000;
            default: op = 32'h0000_0000;
        endcase
        return {op[31:10], X17, insn[4:0]};
    endfunction

    // Form word r_k of the current sequence
    always_comb begin
        logic [4:0] s;
        s    = i_q_desc.target[2] ? X17 : X16;
        word = 32'd0;
        unique case (i_q_desc.kind)
            a64pr_pkg::K_COPY: word = i_q_desc.insn;
            a64pr_pkg::K_NOP:  word = OP_NOP;
            a64pr_pkg::K_FAIL: word = 32'd0;
            a64pr_pkg::K_ADR: begin
                case (r_k)
                    3'd0:    word = ldr_lit(i_q_desc.insn[4:0], 19'd2);
                    3'd1:    word = enc_b(26'd3);
                    3'd2:    word = i_q_desc.target[31:0];
                    default: word = i_q_desc.target[63:32];
                endcase
            end
            a64pr_pkg::K_B: begin
                case (r_k)
                    3'd0:    word = ldr_lit(s, 19'd2);
                    3'd1:    word = OP_BR | {22'b0, s, 5'b0};
                    3'd2:    word = i_q_desc.target[31:0];
                    default: word = i_q_desc.target[63:32];
                endcase
            end
            a64pr_pkg::K_BL: begin
                case (r_k)
                    3'd0:    word = ldr_lit(X16, 19'd3);
                    3'd1:    word = OP_BLR | {22'b0, X16, 5'b0};
                    3'd2:    word = enc_b(26'd3);
                    3'd3:    word = i_q_desc.target[31:0];
                    default: word = i_q_desc.target[63:32];
                endcase
            end
            a64pr_pkg::K_COND19, a64pr_pkg::K_COND14: begin
                case (r_k)
                    3'd0: begin
                        if (i_q_desc.kind == a64pr_pkg::K_COND19) begin
                            word = {i_q_desc.insn[31:24], 19'd2, i_q_desc.insn[4:0]};
                        end else begin
                            word = {i_q_desc.insn[31:19], 14'd2, i_q_desc.insn[4:0]};
                        end
                    end
                    3'd1:    word = enc_b(26'd5);
                    3'd2:    word = ldr_lit(s, 19'd2);
                    3'd3:    word = OP_BR | {22'b0, s, 5'b0};
                    3'd4:    word = i_q_desc.target[31:0];
                    default: word = i_q_desc.target[63:32];
                endcase
            end
            a64pr_pkg::K_LIT: begin
                case (r_k)
                    3'd0:    word = ldr_lit(X17, 19'd2);
                    3'd1:    word = enc_b(26'd3);
                    3'd2:    word = i_q_desc.target[31:0];
                    3'd3:    word = i_q_desc.target[63:32];
                    default: word = lit_load(i_q_desc.insn);
                endcase
            end
            default: word = 32'd0;
        endcase
    end

    assign load   = i_q_valid && (!r_valid || !i_out_stall);
    assign last   = (r_k == (a64pr_pkg::words_of(i_q_desc.kind) - 3'd1));
    assign k_next = r_k + 3'd1;
    assign o_pop  = load && last;

    // Load output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word   <= word;
            r_last   <= last;
            r_status <= i_q_desc.status;
            if (i_q_desc.status != a64pr_pkg::ST_OK) begin
                r_bytes <= 13'd0;
            end else begin
                r_bytes <= i_q_desc.bytes + {8'b0, k_next, 2'b00};
            end
        end
    end

    // Advance word counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= last ? 3'd0 : k_next;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_word        = r_word;
    assign o_word_last   = r_last;
    assign o_status      = r_status;
    assign o_bytes_total = r_bytes;

endmodule

// ----- hw/rtl/arm64_prologue_relocator.sv -----
// ---------------------------------------------------------------------------
// arm64_prologue_relocator
// Streams the instructions of a patched window and emits relocated words.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one instruction word per
//   item, in window order. Output channel: o_out_valid / i_out_stall carry
//   one replacement word per item, with o_word_last on the final word of
//   each instruction, a status code and the running byte count.
//   Configuration: pulse i_cfg_we with i_cfg_index and i_cfg_data; write
//   only while no instruction is in flight.
//   Expansion: an accepted instruction is registered in the descriptor
//   queue, then each of its words in the output stage. The back end emits
//   one word per cycle while the output is not stalled: 1 word (copy, NOP,
//   failure), 4 (ADR/ADRP, B), 5 (BL, literal load) or 6 (conditional branch).
//   A two-entry descriptor queue sits between the decode front end and the
//   expansion back end; o_in_stall rises only while that queue is full.
//   Reset clears window state, empties the queue and sets the registers to
//   base 0, count 1, capacity 4096. When the receiver stalls, the output
//   word holds and the queue fills before input is stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm64_prologue_relocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_word,
    output logic        o_word_last,
    output logic [2:0]  o_status,
    output logic [12:0] o_bytes_total
);

    a64pr_pkg::t_push push;
    a64pr_pkg::t_desc q_desc;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    assign o_in_stall = q_full;

    // Decode and resolve
    a64pr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_instruction (i_instruction),
        .i_full        (q_full),
        .o_push        (push)
    );

    // Decouple front and back
    a64pr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    // Expand into words
    a64pr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_desc      (q_desc),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_word        (o_word),
        .o_word_last   (o_word_last),
        .o_status      (o_status),
        .o_bytes_total (o_bytes_total)
    );

endmodule

// ----- hw/rtl/a64pr_checker.sv -----
// ---------------------------------------------------------------------------
// a64pr_checker
// Port-level checks of the relocator output stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm64_prologue_relocator_macros.svh"

module a64pr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] o_word,
    input  logic        o_word_last,
    input  logic [2:0]  o_status,
    input  logic [12:0] o_bytes_total
);

    // Stalled output holds its word
    `A64PR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_word) && $stable(o_word_last) && $stable(o_status), "stalled output changed")

    // Failure or skip is a single zero word
    `A64PR_ASSERT_IMPL(a_fail_shape, i_clk, i_rst_n, o_out_valid && (o_status != a64pr_pkg::ST_OK), o_word_last && (o_word == 32'd0) && (o_bytes_total == 13'd0), "failure result malformed")

    // Good words carry a nonzero word-aligned byte count
    `A64PR_ASSERT_IMPL(a_bytes_align, i_clk, i_rst_n, o_out_valid && (o_status == a64pr_pkg::ST_OK), (o_bytes_total != 13'd0) && (o_bytes_total[1:0] == 2'b00), "byte count malformed")

    // Within one instruction the count grows by one word per result
    `A64PR_ASSERT_NEXT(a_bytes_step, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_word_last, !o_out_valid || (o_bytes_total == $past(o_bytes_total) + 13'd4) || (o_status != a64pr_pkg::ST_OK), "byte count did not advance")

endmodule

bind arm64_prologue_relocator a64pr_checker u_a64pr_checker (.*);
